FILE: hdl/vbsq_pkg.sv
// Shared types, constants and the CORDIC angle table for the bearing sector quantizer.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package vbsq_pkg;

    // Coordinate and angle formats
    localparam int COORD_WIDTH = 32;
    localparam int ITERATIONS  = 16;
    localparam int ANGLE_BITS  = 24;
    localparam int FIELD_W     = 32;
    localparam int COORD_BITS  = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
    localparam int SCALE_SHIFT = 61 - COORD_BITS;
    localparam int DATA_W      = 64;
    localparam int SHIFT_W     = 5;

    // Sector count and index formats
    localparam int NP_W    = 9;
    localparam int INDEX_W = 8;
    localparam int PROD_W  = NP_W + ANGLE_BITS;
    localparam logic [NP_W-1:0] NP_RESET = 9'd16;
    localparam logic [NP_W-1:0] NP_MAX   = 9'd256;

    // Register stages from input transfer to output valid
    localparam int LATENCY = ITERATIONS + 3;

    // atan(2^-i) / (2*pi) in units of 2^-32 turn
    localparam logic [31:0] TURN_TABLE [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Vector and angle carried from cell to cell
    typedef struct packed {
        logic signed [DATA_W-1:0] north;
        logic signed [DATA_W-1:0] east;
        logic [ANGLE_BITS-1:0]    angle;
        logic                     zero;
    } vbsq_vec_t;

    // Round a table entry to the angle width
    function automatic logic [ANGLE_BITS-1:0] step_angle(input int stage);
        logic [32:0] entry;
        logic [32:0] rounded;
        entry   = {1'b0, TURN_TABLE[stage & 31]};
        rounded = entry;
        if (ANGLE_BITS < 32)
        begin
            rounded = (entry + (33'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
        end
        return rounded[ANGLE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/vbsq_prep.sv
// Input stage: scales the offsets, folds the lower half plane and flags the zero vector.
// Depends on vbsq_pkg.
`default_nettype none

module vbsq_prep (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      in_valid,
    output      logic                                      in_stall,
    input  wire logic signed [vbsq_pkg::FIELD_W-1:0]       east_offset,
    input  wire logic signed [vbsq_pkg::FIELD_W-1:0]       north_offset,
    output      logic                                      out_valid,
    output      vbsq_pkg::vbsq_vec_t                       out_data,
    input  wire logic                                      out_take
);

    localparam int CB = vbsq_pkg::COORD_BITS;
    localparam int DW = vbsq_pkg::DATA_W;
    localparam int AB = vbsq_pkg::ANGLE_BITS;

    logic                 valid_reg;
    logic                 valid_next;
    vbsq_pkg::vbsq_vec_t  data_reg;
    vbsq_pkg::vbsq_vec_t  data_next;
    logic                 take_in;
    logic signed [DW-1:0] east_ext;
    logic signed [DW-1:0] north_ext;

    // Accept when empty or when the content moves on
    assign take_in  = !valid_reg || out_take;
    assign in_stall = !take_in;

    // Sign-extend and scale the coordinates
    assign east_ext  = {{(DW-CB){east_offset[CB-1]}}, east_offset[CB-1:0]};
    assign north_ext = {{(DW-CB){north_offset[CB-1]}}, north_offset[CB-1:0]};

    // Fold the southern half by a half turn
    always_comb
    begin
        data_next.east  = east_ext <<< vbsq_pkg::SCALE_SHIFT;
        data_next.north = north_ext <<< vbsq_pkg::SCALE_SHIFT;
        data_next.angle = '0;
        data_next.zero  = (east_ext == '0) && (north_ext == '0);
        if (north_ext[DW-1])
        begin
            data_next.east  = -(east_ext <<< vbsq_pkg::SCALE_SHIFT);
            data_next.north = -(north_ext <<< vbsq_pkg::SCALE_SHIFT);
            data_next.angle = {1'b1, {(AB-1){1'b0}}};
        end
    end

    assign valid_next = take_in ? in_valid : valid_reg;

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load the payload on each transfer
    always_ff @(posedge clk)
    begin
        if (take_in && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

FILE: hdl/vbsq_cell.sv
// One CORDIC vectoring cell: a micro-rotation toward the north axis and one angle step.
// Depends on vbsq_pkg; the shift and step come in as tied constants.
`default_nettype none

module vbsq_cell (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic [vbsq_pkg::SHIFT_W-1:0]          shift,
    input  wire logic [vbsq_pkg::ANGLE_BITS-1:0]       step,
    input  wire logic                                  in_valid,
    output      logic                                  in_take,
    input  wire vbsq_pkg::vbsq_vec_t                   in_data,
    output      logic                                  out_valid,
    output      vbsq_pkg::vbsq_vec_t                   out_data,
    input  wire logic                                  out_take
);

    localparam int DW = vbsq_pkg::DATA_W;

    logic                 valid_reg;
    logic                 valid_next;
    vbsq_pkg::vbsq_vec_t  data_reg;
    vbsq_pkg::vbsq_vec_t  data_next;
    logic signed [DW-1:0] east_shr;
    logic signed [DW-1:0] north_shr;

    assign in_take = !valid_reg || out_take;

    // Floor shifts of both components
    assign east_shr  = in_data.east >>> shift;
    assign north_shr = in_data.north >>> shift;

    // Rotate toward east = 0, steering by the sign of east
    always_comb
    begin
        data_next = in_data;
        if (!in_data.east[DW-1])
        begin
            data_next.north = in_data.north + east_shr;
            data_next.east  = in_data.east - north_shr;
            data_next.angle = in_data.angle + step;
        end
        else
        begin
            data_next.north = in_data.north - east_shr;
            data_next.east  = in_data.east + north_shr;
            data_next.angle = in_data.angle - step;
        end
    end

    assign valid_next = in_take ? in_valid : valid_reg;

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (in_take && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

FILE: hdl/vbsq_index.sv
// Sector index stage: scales the bearing by the sector count, rounds and wraps.
// Depends on vbsq_pkg. Two registers: product, then the output register.
`default_nettype none

module vbsq_index (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic [vbsq_pkg::NP_W-1:0]             sector_count,
    input  wire logic                                  in_valid,
    output      logic                                  in_take,
    input  wire vbsq_pkg::vbsq_vec_t                   in_data,
    output      logic                                  out_valid,
    output      logic [vbsq_pkg::INDEX_W-1:0]          sector_index,
    input  wire logic                                  out_take
);

    localparam int AB = vbsq_pkg::ANGLE_BITS;
    localparam int NW = vbsq_pkg::NP_W;
    localparam int PW = vbsq_pkg::PROD_W;

    logic                              mul_valid_reg;
    logic                              mul_valid_next;
    logic [PW-1:0]                     prod_reg;
    logic                              zero_reg;
    logic                              res_valid_reg;
    logic                              res_valid_next;
    logic [vbsq_pkg::INDEX_W-1:0]      index_reg;
    logic [vbsq_pkg::INDEX_W-1:0]      index_next;
    logic                              res_take;
    logic [NW-1:0]                     np_eff;
    logic [PW-1:0]                     prod_next;
    logic [PW:0]                       rounded;
    logic [NW:0]                       raw_index;

    // Clamp the sector count
    assign np_eff = (sector_count > vbsq_pkg::NP_MAX) ? vbsq_pkg::NP_MAX : sector_count;

    assign res_take = !res_valid_reg || out_take;
    assign in_take  = !mul_valid_reg || res_take;

    // Scale the bearing by the sector count
    assign prod_next = {{AB{1'b0}}, np_eff} * {{NW{1'b0}}, in_data.angle};

    // Round to nearest and wrap the full count to zero
    assign rounded   = {1'b0, prod_reg} + ((PW+1)'(1) << (AB - 1));
    assign raw_index = rounded[PW:AB];

    always_comb
    begin
        index_next = raw_index[vbsq_pkg::INDEX_W-1:0];
        if (zero_reg || (raw_index >= {1'b0, np_eff}))
        begin
            index_next = '0;
        end
    end

    assign mul_valid_next = in_take ? in_valid : mul_valid_reg;
    assign res_valid_next = res_take ? mul_valid_reg : res_valid_reg;

    // Hold both valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= mul_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Load the product stage
    always_ff @(posedge clk)
    begin
        if (in_take && in_valid)
        begin
            prod_reg <= prod_next;
            zero_reg <= in_data.zero;
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (res_take && mul_valid_reg)
        begin
            index_reg <= index_next;
        end
    end

    assign out_valid    = res_valid_reg;
    assign sector_index = index_reg;

endmodule

`default_nettype wire

FILE: hdl/vector_bearing_sector_quantizer_unit.sv
// Bearing sector quantizer: top level with the configuration register and the cell chain.
// Depends on vbsq_pkg, vbsq_prep, vbsq_cell and vbsq_index.
//
// Usage:
//  Input channel (in_valid / in_stall) carries east_offset and north_offset, two's complement.
//  Output channel (out_valid / out_stall) carries sector_index: the nearest of sector count
//  equal sectors, 0 at north, counting clockwise. A zero vector gives sector 0.
//  Configuration channel (cfg_valid / cfg_ready / cfg_data) writes the sector count;
//  cfg_ready is always high. Write it only while no transfer is in flight.
//  Registers from input transfer to out_valid: one input register, one register per CORDIC
//  cell, 16 cells, then the product register and the output register.
//  Throughput: one vector per clock unless stalled; each stage is a register with a valid bit.
//  Stall: while out_stall is high the output register holds its result; stages behind it keep
//  filling bubbles and in_stall rises only once every stage holds an item.
//  Reset: clears all valid bits and sets the sector count to 16; no clearing pass is needed.
`default_nettype none

module vector_bearing_sector_quantizer_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_valid,
    output      logic                                  cfg_ready,
    input  wire logic [vbsq_pkg::NP_W-1:0]             cfg_data,
    input  wire logic                                  in_valid,
    output      logic                                  in_stall,
    input  wire logic signed [vbsq_pkg::FIELD_W-1:0]   east_offset,
    input  wire logic signed [vbsq_pkg::FIELD_W-1:0]   north_offset,
    output      logic                                  out_valid,
    input  wire logic                                  out_stall,
    output      logic [vbsq_pkg::INDEX_W-1:0]          sector_index
);

    localparam int NI = vbsq_pkg::ITERATIONS;

    logic [vbsq_pkg::NP_W-1:0] sector_count_reg;
    logic [vbsq_pkg::NP_W-1:0] sector_count_next;
    logic [NI:0]               chain_valid;
    logic [NI:0]               chain_take;
    vbsq_pkg::vbsq_vec_t       chain_data [0:NI];

    // Configuration register
    assign cfg_ready         = 1'b1;
    assign sector_count_next = (cfg_valid && cfg_ready) ? cfg_data : sector_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_count_reg <= vbsq_pkg::NP_RESET;
        end
        else
        begin
            sector_count_reg <= sector_count_next;
        end
    end

    // Input register
    vbsq_prep u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .east_offset  (east_offset),
        .north_offset (north_offset),
        .out_valid    (chain_valid[0]),
        .out_data     (chain_data[0]),
        .out_take     (chain_take[0])
    );

    // CORDIC cell chain
    for (genvar g = 0; g < NI; g++)
    begin : g_cell
        localparam int CELL_SHIFT_INT = g % 32;
        localparam logic [vbsq_pkg::SHIFT_W-1:0] CELL_SHIFT =
            CELL_SHIFT_INT[vbsq_pkg::SHIFT_W-1:0];
        localparam logic [vbsq_pkg::ANGLE_BITS-1:0] CELL_STEP = vbsq_pkg::step_angle(g);

        vbsq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (CELL_SHIFT),
            .step      (CELL_STEP),
            .in_valid  (chain_valid[g]),
            .in_take   (chain_take[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_data  (chain_data[g+1]),
            .out_take  (chain_take[g+1])
        );
    end

    // Index and output register
    vbsq_index u_index (
        .clk          (clk),
        .rst_n        (rst_n),
        .sector_count (sector_count_reg),
        .in_valid     (chain_valid[NI]),
        .in_take      (chain_take[NI]),
        .in_data      (chain_data[NI]),
        .out_valid    (out_valid),
        .sector_index (sector_index),
        .out_take     (!out_stall)
    );

endmodule

`default_nettype wire

FILE: hdl/vbsq_checker.sv
// Port-level checks for the bearing sector quantizer, bound to the top level.
// Depends on vbsq_pkg and vector_bearing_sector_quantizer_unit.
`default_nettype none

module vbsq_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic [vbsq_pkg::INDEX_W-1:0]      sector_index
);

    // Input stalls only when the output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output free");

    // A result after an empty output came straight through the chain
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, vbsq_pkg::LATENCY))
        else $error("result without matching input transfer");

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result dropped");

    // A stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(sector_index))
        else $error("stalled result changed");

endmodule

bind vector_bearing_sector_quantizer_unit vbsq_checker u_vbsq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sector_index (sector_index)
);

`default_nettype wire
